// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds through reset
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/hap_pkg.sv
// Package for the action reply parser: phase codes, character codes, field widths and the parse state type.
package hap_pkg;

  // Parse phases
  localparam logic [2:0] PH_SEEK_COLON  = 3'd0;
  localparam logic [2:0] PH_SKIP_SPACE  = 3'd1;
  localparam logic [2:0] PH_FIELD0      = 3'd2;
  localparam logic [2:0] PH_SEEK_COMMA1 = 3'd3;
  localparam logic [2:0] PH_FIELD1      = 3'd4;
  localparam logic [2:0] PH_SEEK_COMMA2 = 3'd5;
  localparam logic [2:0] PH_FIELD2      = 3'd6;
  localparam logic [2:0] PH_DONE        = 3'd7;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Field widths
  localparam int unsigned METHOD_W = 8;
  localparam int unsigned STATUS_W = 16;
  localparam int unsigned LENGTH_W = 32;
  localparam int unsigned OUT_W    = METHOD_W + STATUS_W + LENGTH_W;

  typedef struct packed {
    logic [2:0]          phase;
    logic [METHOD_W-1:0] method;
    logic [STATUS_W-1:0] status;
    logic [LENGTH_W-1:0] length;
  } hap_state_t;

  localparam hap_state_t STATE_INIT = '{phase: PH_SEEK_COLON, method: '0,
                                        status: '0, length: '0};

endpackage

// File: sv/hap_step.sv
// Next-state logic of the parser: applies one line byte to the parse state.
module hap_step (
  input  hap_pkg::hap_state_t cur,
  input  logic [7:0]          line_byte,
  output hap_pkg::hap_state_t nxt
);

  logic       is_digit;
  logic       is_comma;
  logic [3:0] digit;
  logic [2:0] eff_phase;

  assign is_digit = (line_byte >= hap_pkg::CH_ZERO) && (line_byte <= hap_pkg::CH_NINE);
  assign is_comma = (line_byte == hap_pkg::CH_COMMA);
  assign digit    = 4'(line_byte - hap_pkg::CH_ZERO);

  // A non-space after the colon opens the first field and is parsed as part of it
  always_comb begin
    eff_phase = cur.phase;
    if ((cur.phase == hap_pkg::PH_SKIP_SPACE) && (line_byte != hap_pkg::CH_SPACE)) begin
      eff_phase = hap_pkg::PH_FIELD0;
    end
  end

  // Advance phase and accumulate digits; x10 as shift and add
  always_comb begin
    nxt       = cur;
    nxt.phase = eff_phase;
    case (eff_phase)
      hap_pkg::PH_SEEK_COLON: begin
        if (line_byte == hap_pkg::CH_COLON) nxt.phase = hap_pkg::PH_SKIP_SPACE;
      end
      hap_pkg::PH_SKIP_SPACE: begin
        nxt.phase = hap_pkg::PH_SKIP_SPACE;
      end
      hap_pkg::PH_FIELD0: begin
        if (is_digit) begin
          nxt.method = (cur.method << 3) + (cur.method << 1)
                     + hap_pkg::METHOD_W'(digit);
        end else begin
          nxt.phase = is_comma ? hap_pkg::PH_FIELD1 : hap_pkg::PH_SEEK_COMMA1;
        end
      end
      hap_pkg::PH_SEEK_COMMA1: begin
        if (is_comma) nxt.phase = hap_pkg::PH_FIELD1;
      end
      hap_pkg::PH_FIELD1: begin
        if (is_digit) begin
          nxt.status = (cur.status << 3) + (cur.status << 1)
                     + hap_pkg::STATUS_W'(digit);
        end else begin
          nxt.phase = is_comma ? hap_pkg::PH_FIELD2 : hap_pkg::PH_SEEK_COMMA2;
        end
      end
      hap_pkg::PH_SEEK_COMMA2: begin
        if (is_comma) nxt.phase = hap_pkg::PH_FIELD2;
      end
      hap_pkg::PH_FIELD2: begin
        if (is_digit) begin
          nxt.length = (cur.length << 3) + (cur.length << 1)
                     + hap_pkg::LENGTH_W'(digit);
        end else begin
          nxt.phase = hap_pkg::PH_DONE;
        end
      end
      default: begin
        nxt.phase = hap_pkg::PH_DONE;
      end
    endcase
    // Terminator stops parsing for the rest of the line
    if (line_byte == hap_pkg::CH_NUL) nxt.phase = hap_pkg::PH_DONE;
  end

endmodule

// File: sv/http_action_reply_parser_top.sv
// Top level of the action reply parser: input register, step logic, result register.
// Takes one reply-line byte per beat at full rate, one beat every cycle unless the
// result side stalls, and returns one result beat (method, status, length) for each
// beat marked with tlast. A byte is held in the input register, where the
// combinational step logic applies it to the parse state; on a tlast beat the result
// is loaded into the output register. The parse state returns to its reset value
// after every tlast beat. Back-pressure on the result side stalls both stages.
module http_action_reply_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] line_byte
  input  logic        in_tlast,   // end_of_line
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [7:0] method_code, [23:8] status_code,
                                  // [55:24] content_length
);

  logic                s0_valid_r;
  logic [7:0]          s0_byte_r;
  logic                s0_last_r;
  logic                s0_advance;
  hap_pkg::hap_state_t st_r;
  hap_pkg::hap_state_t st_step;
  logic                out_valid_r;
  logic [55:0]         out_data_r;

  // Input stage moves on when the result register is free or being drained
  assign s0_advance = !out_valid_r || out_tready;
  assign in_tready  = !s0_valid_r || s0_advance;

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s0_byte_r <= in_tdata;
      s0_last_r <= in_tlast;
    end
  end

  hap_step u_step (
    .cur       (st_r),
    .line_byte (s0_byte_r),
    .nxt       (st_step)
  );

  // Update parse state; restart after the last byte of a line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hap_pkg::STATE_INIT;
    end else if (s0_valid_r && s0_advance) begin
      st_r <= s0_last_r ? hap_pkg::STATE_INIT : st_step;
    end
  end

  // Load the result register on a last byte, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_advance) begin
      out_valid_r <= s0_valid_r && s0_last_r;
    end
    if (s0_advance && s0_valid_r && s0_last_r) begin
      out_data_r <= {st_step.length, st_step.status, st_step.method};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: sv/hap_checker.sv
// Port-level checker for the action reply parser, bound to the top level.
`include "assert_macros.svh"

module hap_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  logic [1:0] pend_r;
  logic       in_last_beat;
  logic       out_beat;

  assign in_last_beat = in_tvalid && in_tready && in_tlast;
  assign out_beat     = out_tvalid && out_tready;

  // Count line ends accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_r + 2'(in_last_beat) - 2'(out_beat);
    end
  end

  `ASSERT_CLK_NR(a_idle_after_reset, clk, $past(!rst_n) |-> !out_tvalid, "result beat right after reset")
  `ASSERT_CLK(a_no_invented, clk, rst_n, out_tvalid |-> (pend_r != 2'd0), "result beat without a line end")
  `ASSERT_CLK(a_bounded, clk, rst_n, (pend_r == 2'd0) || (pend_r == 2'd1) || (pend_r == 2'd2), "more line ends in flight than stages")
  `ASSERT_CLK(a_hold_stall, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "stalled result beat changed")

endmodule

bind http_action_reply_parser_top hap_checker u_hap_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
